### hdl/hdrtm_pkg.sv
// Package for the HDR tone map block: word types, register indexes and root functions.
// Used by hdrtm_channel and hdr_tone_map_gamma_quantize; depends on nothing.
`default_nettype none
package hdrtm_pkg;

   typedef struct packed {
      logic [11:0]        column;
      logic [11:0]        row;
      logic signed [31:0] red_hdr;
      logic signed [31:0] green_hdr;
      logic signed [31:0] blue_hdr;
   } req_type;

   typedef struct packed {
      logic [23:0] out_address;
      logic [7:0]  red_byte;
      logic [7:0]  green_byte;
      logic [7:0]  blue_byte;
      logic [16:0] red_display;
      logic [16:0] green_display;
      logic [16:0] blue_display;
   } rsp_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPOSURE_GAIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_GAMMA = 3'd3;

   localparam int FRAC_BITS = 16;

   function automatic logic [63:0] floor_sqrt64(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = value;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(2^-idx) in Q.30, each step the floor square root of the one before
   function automatic logic [30:0] root_q30(input int idx);
      logic [63:0] root;
      root = 64'd1 << 31;
      for (int i = 1; i <= FRAC_BITS; i++) begin
         if (i <= idx) begin
            root = floor_sqrt64(root << 30);
         end
      end
      return root[30:0];
   endfunction

endpackage
`default_nettype wire

### hdl/hdr_tone_map_gamma_quantize.sv
// Top level of the HDR tone map: registers, address path, three channel pipelines.
// Depends on hdrtm_pkg and hdrtm_channel.
//
// Usage:
//   Drive req_data and raise start; a word is taken at each edge with start high
//   and busy low. busy stays low, so one pixel can enter every cycle.
//   Each result word appears on rsp_data with rsp_strobe high for one cycle;
//   throughput is one pixel per cycle.
//   The latency is set mostly by the sixteen squaring stages of the log2 and the
//   sixteen root multiply stages of the exp2, one 31x31 multiply per stage.
//   The receiver cannot stall: results must be taken as they come.
//   Write registers through csr_write_enable, csr_index and csr_write_data
//   while no pixel is in flight; unknown indexes are ignored.
//   Synchronous reset clears the valid line and sets the registers to width 1,
//   height 1, gain 1.0 and inverse gamma 1.0; words in flight are dropped.
`default_nettype none
module hdr_tone_map_gamma_quantize #(
   parameter int MAX_DIM = 4096
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire hdrtm_pkg::req_type                  req_data,
   output logic                                     rsp_strobe,
   output hdrtm_pkg::rsp_type                       rsp_data,
   input  wire logic                                csr_write_enable,
   input  wire logic [hdrtm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [hdrtm_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import hdrtm_pkg::*;

   localparam int LATENCY = 38;

   logic [12:0] width_ff;
   logic [12:0] height_ff;
   logic [23:0] gain_ff;
   logic [15:0] gamma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd1;
         height_ff <= 13'd1;
         gain_ff   <= 24'd65536;
         gamma_ff  <= 16'd4096;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff  <= csr_write_data[12:0];
            CSR_IMAGE_HEIGHT:  height_ff <= csr_write_data[12:0];
            CSR_EXPOSURE_GAIN: gain_ff   <= csr_write_data;
            CSR_INVERSE_GAMMA: gamma_ff  <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   logic [LATENCY-1:0] valid_ff;
   logic [LATENCY-1:0] valid_in;
   assign valid_in = {valid_ff[LATENCY-2:0], accept};
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // flipped address, clamped dimensions
   logic [23:0] w_eff;
   logic [23:0] h_eff;
   logic [23:0] rows_in;
   logic [23:0] addr_line_ff [0:LATENCY-1];
   assign w_eff   = ({11'd0, width_ff} > 24'(MAX_DIM))  ? 24'(MAX_DIM) : {11'd0, width_ff};
   assign h_eff   = ({11'd0, height_ff} > 24'(MAX_DIM)) ? 24'(MAX_DIM) : {11'd0, height_ff};
   assign rows_in = h_eff - 24'd1 - {12'd0, req_data.row};
   always_ff @(posedge clock) begin
      addr_line_ff[0] <= rows_in * w_eff + {12'd0, req_data.column};
      for (int i = 1; i < LATENCY; i++) begin
         addr_line_ff[i] <= addr_line_ff[i-1];
      end
   end

   logic [16:0] disp_r, disp_g, disp_b;
   logic [7:0]  byte_r, byte_g, byte_b;

   hdrtm_channel u_red (
      .clock(clock), .raw(req_data.red_hdr), .exposure_gain(gain_ff),
      .inverse_gamma(gamma_ff), .display(disp_r), .byte_value(byte_r)
   );
   hdrtm_channel u_green (
      .clock(clock), .raw(req_data.green_hdr), .exposure_gain(gain_ff),
      .inverse_gamma(gamma_ff), .display(disp_g), .byte_value(byte_g)
   );
   hdrtm_channel u_blue (
      .clock(clock), .raw(req_data.blue_hdr), .exposure_gain(gain_ff),
      .inverse_gamma(gamma_ff), .display(disp_b), .byte_value(byte_b)
   );

   assign rsp_strobe             = valid_ff[LATENCY-1];
   assign rsp_data.out_address   = addr_line_ff[LATENCY-1];
   assign rsp_data.red_byte      = byte_r;
   assign rsp_data.green_byte    = byte_g;
   assign rsp_data.blue_byte     = byte_b;
   assign rsp_data.red_display   = disp_r;
   assign rsp_data.green_display = disp_g;
   assign rsp_data.blue_display  = disp_b;

   a_red_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (disp_r <= 17'd65536 && disp_g <= 17'd65536 && disp_b <= 17'd65536))
      else $error("display value above 1.0");

   a_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && disp_r == 17'd65536) |-> (byte_r == 8'd255))
      else $error("full scale red not quantized to 255");

   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && disp_g == 17'd0) |-> (byte_g == 8'd0))
      else $error("black green not quantized to 0");

endmodule
`default_nettype wire

### hdl/hdrtm_channel.sv
// One colour channel of the tone map: exposure multiply, log2, gamma scale, exp2, quantize.
// Free-running pipeline of 38 stages; depends on hdrtm_pkg.
`default_nettype none
module hdrtm_channel (
   input  wire logic        clock,
   input  wire logic [31:0] raw,
   input  wire logic [23:0] exposure_gain,
   input  wire logic [15:0] inverse_gamma,
   output logic [16:0]      display,
   output logic [7:0]       byte_value
);
   import hdrtm_pkg::*;

   // exposure multiply
   logic [54:0] p_a_ff;
   always_ff @(posedge clock) begin
      p_a_ff <= raw[31] ? 55'd0 : 55'(raw[30:0]) * 55'(exposure_gain);
   end

   // leading one
   logic [5:0]  k_in;
   logic [54:0] p_b_ff;
   logic [5:0]  k_b_ff;
   logic        zero_b_ff;
   always_comb begin
      k_in = 6'd0;
      for (int i = 0; i < 55; i++) begin
         if (p_a_ff[i]) k_in = 6'(i);
      end
   end
   always_ff @(posedge clock) begin
      p_b_ff    <= p_a_ff;
      k_b_ff    <= k_in;
      zero_b_ff <= (p_a_ff == 55'd0);
   end

   // normalise to Q.30 and square sixteen times
   logic [30:0]        sqm_ff  [0:FRAC_BITS];
   logic [15:0]        frac_ff [0:FRAC_BITS];
   logic [5:0]         k_ff    [0:FRAC_BITS];
   logic               zsq_ff  [0:FRAC_BITS];
   logic [84:0]        norm_in;
   assign norm_in = ({30'd0, p_b_ff} << 30) >> k_b_ff;
   always_ff @(posedge clock) begin
      sqm_ff[0]  <= norm_in[30:0];
      frac_ff[0] <= 16'd0;
      k_ff[0]    <= k_b_ff;
      zsq_ff[0]  <= zero_b_ff;
   end
   for (genvar j = 0; j < FRAC_BITS; j++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] t;
      assign sq = {31'd0, sqm_ff[j]} * {31'd0, sqm_ff[j]};
      assign t  = sq[61:30];
      always_ff @(posedge clock) begin
         sqm_ff[j+1]  <= t[31] ? t[31:1] : t[30:0];
         frac_ff[j+1] <= {frac_ff[j][14:0], t[31]};
         k_ff[j+1]    <= k_ff[j];
         zsq_ff[j+1]  <= zsq_ff[j];
      end
   end

   // scale log2 by the inverse gamma
   logic [5:0]         km_in;
   logic signed [38:0] lx;
   logic signed [38:0] gx;
   logic signed [38:0] prod_ff;
   logic               zero_e_ff;
   assign km_in = k_ff[FRAC_BITS] - 6'd32;
   assign lx    = 39'($signed({km_in, frac_ff[FRAC_BITS]}));
   assign gx    = 39'($signed({1'b0, inverse_gamma}));
   always_ff @(posedge clock) begin
      prod_ff   <= lx * gx;
      zero_e_ff <= zsq_ff[FRAC_BITS];
   end

   // split the exponent into integer shift and fraction
   logic [38:0] neg_in;
   logic [38:0] em_sum;
   logic [26:0] emag_in;
   logic [27:0] q_sum;
   logic [11:0] q_in;
   logic [30:0] acc_ff [1:FRAC_BITS];
   logic [15:0] fp_ff  [0:FRAC_BITS];
   logic [4:0]  q_ff   [0:FRAC_BITS];
   logic        big_ff [0:FRAC_BITS];
   logic        sat_ff [0:FRAC_BITS];
   logic        zp_ff  [0:FRAC_BITS];
   assign neg_in  = 39'(-prod_ff);
   assign em_sum  = neg_in + 39'd4095;
   assign emag_in = em_sum[38:12];
   assign q_sum   = {1'b0, emag_in} + 28'd65535;
   assign q_in    = q_sum[27:16];
   always_ff @(posedge clock) begin
      fp_ff[0]  <= (~emag_in[15:0]) + 16'd1;
      q_ff[0]   <= q_in[4:0];
      big_ff[0] <= (q_in >= 12'd17);
      sat_ff[0] <= !prod_ff[38];
      zp_ff[0]  <= zero_e_ff;
   end

   // exp2 of the fraction as a product of constant roots
   for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_pow
      localparam logic [30:0] ROOT = root_q30(j);
      logic [30:0] acc_prev;
      logic [61:0] mul;
      if (j == 1) begin : g_first
         assign acc_prev = 31'd1 << 30;
      end else begin : g_next
         assign acc_prev = acc_ff[j-1];
      end
      assign mul = {31'd0, acc_prev} * {31'd0, ROOT};
      always_ff @(posedge clock) begin
         acc_ff[j] <= fp_ff[j-1][FRAC_BITS-j] ? mul[60:30] : acc_prev;
         fp_ff[j]  <= fp_ff[j-1];
         q_ff[j]   <= q_ff[j-1];
         big_ff[j] <= big_ff[j-1];
         sat_ff[j] <= sat_ff[j-1];
         zp_ff[j]  <= zp_ff[j-1];
      end
   end

   // final shift and 8-bit quantize
   logic [4:0]  sh;
   logic [30:0] shifted;
   logic [16:0] d_in;
   logic [25:0] scaled;
   assign sh      = 5'd14 + q_ff[FRAC_BITS];
   assign shifted = acc_ff[FRAC_BITS] >> sh;
   always_comb begin
      priority if (zp_ff[FRAC_BITS]) begin
         d_in = 17'd0;
      end else if (sat_ff[FRAC_BITS]) begin
         d_in = 17'd65536;
      end else if (big_ff[FRAC_BITS]) begin
         d_in = 17'd0;
      end else begin
         d_in = shifted[16:0];
      end
   end
   assign scaled = {1'b0, d_in, 8'd0} - {9'd0, d_in} + 26'd32768;
   always_ff @(posedge clock) begin
      display    <= d_in;
      byte_value <= scaled[23:16];
   end

endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for hdr_tone_map_gamma_quantize: directed and random pixels with a
// self-contained tone map predictor and an in-order result checker.
// Depends on hdrtm_pkg and the RTL of the block.
`default_nettype none
module tb_top;
   import hdrtm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   hdr_tone_map_gamma_quantize uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PIPE_DEPTH = 38;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   logic [12:0] img_width;
   logic [12:0] img_height;
   logic [23:0] gain;
   logic [15:0] inv_gamma;
   rsp_type pending_pixels[$];
   int mismatches = 0;
   int idle_pct = 0;
   int stall_count = 0;

   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = value;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [16:0] gamma_channel(input logic [31:0] raw);
      logic [63:0] p;
      logic [63:0] m;
      logic [63:0] e_mag;
      logic [63:0] q;
      logic [63:0] f;
      logic [63:0] acc;
      logic [63:0] root;
      logic [63:0] s;
      longint frac;
      longint lg;
      longint prod;
      int k;
      if (raw == 0 || raw[31]) return 0;
      p = {32'd0, raw} * {40'd0, gain};
      if (p == 0) return 0;
      k = 63;
      while (k > 0 && !p[k]) k--;
      m = (k >= 30) ? (p >> (k - 30)) : (p << (30 - k));
      frac = 0;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      lg = (longint'(k) - 32) * 65536 + frac;
      prod = lg * longint'({48'd0, inv_gamma});
      if (prod >= 0) return 17'd65536;
      e_mag = (64'(-prod) + 4095) >> 12;
      q = (e_mag + 65535) >> 16;
      f = q * 65536 - e_mag;
      acc = 64'd1 << 30;
      root = 64'd1 << 31;
      for (int i = 1; i <= 16; i++) begin
         root = isqrt64(root << 30);
         if (f[16-i]) acc = (acc * root) >> 30;
      end
      s = 14 + q;
      if (s >= 64) return 0;
      return 17'(acc >> s);
   endfunction

   function automatic rsp_type tone_map_pixel(input req_type px);
      rsp_type r;
      logic [31:0] w;
      logic [31:0] h;
      logic [31:0] addr;
      logic [63:0] t;
      logic [16:0] d[3];
      w = (img_width > 4096) ? 32'd4096 : {19'd0, img_width};
      h = (img_height > 4096) ? 32'd4096 : {19'd0, img_height};
      addr = (h - 32'd1 - {20'd0, px.row}) * w + {20'd0, px.column};
      r.out_address = addr[23:0];
      d[0] = gamma_channel(px.red_hdr);
      d[1] = gamma_channel(px.green_hdr);
      d[2] = gamma_channel(px.blue_hdr);
      t = {47'd0, d[0]} * 255 + 32768;
      r.red_byte = t[23:16];
      t = {47'd0, d[1]} * 255 + 32768;
      r.green_byte = t[23:16];
      t = {47'd0, d[2]} * 255 + 32768;
      r.blue_byte = t[23:16];
      r.red_display = d[0];
      r.green_display = d[1];
      r.blue_display = d[2];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_data);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.out_address !== want.out_address
                  || rsp_data.red_byte !== want.red_byte
                  || rsp_data.green_byte !== want.green_byte
                  || rsp_data.blue_byte !== want.blue_byte
                  || rsp_data.red_display !== want.red_display
                  || rsp_data.green_display !== want.green_display
                  || rsp_data.blue_display !== want.blue_display) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch addr %h/%h bytes %h %h %h/%h %h %h disp %h %h %h/%h %h %h",
                     want.out_address, rsp_data.out_address, want.red_byte,
                     want.green_byte, want.blue_byte, rsp_data.red_byte,
                     rsp_data.green_byte, rsp_data.blue_byte, want.red_display,
                     want.green_display, want.blue_display, rsp_data.red_display,
                     rsp_data.green_display, rsp_data.blue_display);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_count <= 0;
      end else if (stall_count >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [23:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH: img_width = value[12:0];
         CSR_IMAGE_HEIGHT: img_height = value[12:0];
         CSR_EXPOSURE_GAIN: gain = value;
         CSR_INVERSE_GAMMA: inv_gamma = value[15:0];
         default: ;
      endcase
   endtask

   task automatic send_pixel(input req_type px);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_data <= px;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_pixels.push_back(tone_map_pixel(px));
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_channel;
      case ($urandom_range(9))
         0: return $urandom;
         1: return 32'd0;
         2: return 32'h8000_0000 | $urandom;
         3: return $urandom_range(1, 255);
         default: return $urandom_range(1, 32'h0004_0000);
      endcase
   endfunction

   function automatic req_type pick_pixel;
      req_type px;
      px.column = 12'($urandom);
      px.row = 12'($urandom);
      px.red_hdr = pick_channel();
      px.green_hdr = pick_channel();
      px.blue_hdr = pick_channel();
      return px;
   endfunction

   function automatic req_type make_pixel(input logic [11:0] c, input logic [11:0] r,
                                          input logic [31:0] v);
      req_type px;
      px.column = c;
      px.row = r;
      px.red_hdr = v;
      px.green_hdr = v ^ 32'h0000_1000;
      px.blue_hdr = v >> 1;
      return px;
   endfunction

   task automatic test_reset_defaults;
      send_pixel(make_pixel(12'd0, 12'd0, 32'h0001_0000));
      send_pixel(make_pixel(12'd5, 12'd0, 32'h0000_8000));
      drain();
   endtask

   task automatic test_directed;
      write_reg(CSR_IMAGE_WIDTH, 24'd4096);
      write_reg(CSR_IMAGE_HEIGHT, 24'd4096);
      send_pixel(make_pixel(12'd0, 12'd0, 32'd0));
      send_pixel(make_pixel(12'd4095, 12'd4095, 32'h7FFF_FFFF));
      send_pixel(make_pixel(12'd4095, 12'd0, 32'h8000_0000));
      send_pixel(make_pixel(12'd1, 12'd1, 32'hFFFF_FFFF));
      send_pixel(make_pixel(12'd7, 12'd9, 32'd1));
      drain();
      write_reg(CSR_IMAGE_WIDTH, 24'hFF_FFFF);
      write_reg(CSR_IMAGE_HEIGHT, 24'd0);
      write_reg(CSR_EXPOSURE_GAIN, 24'hFF_FFFF);
      write_reg(CSR_INVERSE_GAMMA, 24'd1);
      send_pixel(make_pixel(12'd4095, 12'd4095, 32'd1));
      send_pixel(make_pixel(12'd0, 12'd100, 32'h7FFF_FFFF));
      send_pixel(make_pixel(12'd33, 12'd0, 32'h0000_0100));
      drain();
      write_reg(CSR_IMAGE_WIDTH, 24'd0);
      write_reg(CSR_IMAGE_HEIGHT, 24'd8191);
      write_reg(CSR_EXPOSURE_GAIN, 24'd0);
      write_reg(CSR_INVERSE_GAMMA, 24'hFFFF);
      send_pixel(make_pixel(12'd12, 12'd3, 32'h0001_0000));
      drain();
      write_reg(CSR_EXPOSURE_GAIN, 24'd1);
      send_pixel(make_pixel(12'd0, 12'd0, 32'd1));
      send_pixel(make_pixel(12'd0, 12'd0, 32'h7FFF_FFFF));
      drain();
      write_reg(CSR_EXPOSURE_GAIN, 24'd65536);
      write_reg(CSR_INVERSE_GAMMA, 24'd0);
      send_pixel(make_pixel(12'd2, 12'd2, 32'd0));
      send_pixel(make_pixel(12'd2, 12'd2, 32'h0000_0040));
      drain();
      write_reg(CSR_SPARE_LOW, 24'hFF_FFFF);
      write_reg(CSR_SPARE_HIGH, 24'd0);
      write_reg(CSR_INVERSE_GAMMA, 24'd9830);
      write_reg(CSR_IMAGE_WIDTH, 24'd1);
      write_reg(CSR_IMAGE_HEIGHT, 24'd1);
      send_pixel(make_pixel(12'd0, 12'd0, 32'h0000_4000));
      send_pixel(make_pixel(12'd0, 12'd0, 32'h0000_FFFF));
      send_pixel(make_pixel(12'd0, 12'd0, 32'h0001_0000));
      drain();
   endtask

   task automatic test_random(input int sender_idle, input int count);
      idle_pct = sender_idle;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            drain();
            case ($urandom_range(3))
               0: write_reg(CSR_IMAGE_WIDTH, 24'($urandom));
               default: write_reg(CSR_IMAGE_WIDTH, 24'($urandom_range(1, 4096)));
            endcase
            case ($urandom_range(3))
               0: write_reg(CSR_IMAGE_HEIGHT, 24'($urandom));
               default: write_reg(CSR_IMAGE_HEIGHT, 24'($urandom_range(1, 4096)));
            endcase
            case ($urandom_range(2))
               0: write_reg(CSR_EXPOSURE_GAIN, 24'($urandom));
               default: write_reg(CSR_EXPOSURE_GAIN, 24'($urandom_range(4096, 262144)));
            endcase
            case ($urandom_range(2))
               0: write_reg(CSR_INVERSE_GAMMA, 24'($urandom_range(1, 65535)));
               default: write_reg(CSR_INVERSE_GAMMA, 24'($urandom_range(1000, 12000)));
            endcase
         end
         send_pixel(pick_pixel());
      end
      drain();
   endtask

   initial begin
      start <= 1'b0;
      req_data <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      img_width = 13'd1;
      img_height = 13'd1;
      gain = 24'd65536;
      inv_gamma = 16'd4096;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed();
      test_random(14, 700);
      test_random(67, 650);
      test_random(0, 650);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
hdl/hdrtm_pkg.sv
hdl/hdrtm_channel.sv
hdl/hdr_tone_map_gamma_quantize.sv
tb/tb_top.sv
